/* rtl/kar_pkg.sv */
// shared types, constants and helpers for the key event auto-repeat block
package kar_pkg;

    localparam int KeyCount = 4;
    localparam int KeyIdxW = (KeyCount > 1) ? $clog2(KeyCount) : 1;
    localparam int CountW = 8;
    localparam int DelayW = 8;
    localparam int PeriodW = 6;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 8;

    localparam logic [DelayW-1:0] DelayReset = 8'd40;
    localparam logic [PeriodW-1:0] PeriodReset = 6'd5;
    localparam logic [CountW-1:0] CountMax = '1;

    localparam logic [CfgIdxW-1:0] CfgRepeatDelay = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgRepeatPeriod = 2'd1;

    // one tick's worth of work handed from front to back
    typedef struct packed {
        logic [KeyCount-1:0] change;
        logic [KeyCount-1:0] levels;
        logic [KeyCount-1:0] repeat_keys;
    } t_plan;

    // index of the lowest set bit, zero when none is set
    function automatic logic [KeyIdxW-1:0] lowest_set(input logic [KeyCount-1:0] mask);
        logic [KeyIdxW-1:0] idx;
        idx = '0;
        for (int k = KeyCount - 1; k >= 0; k--) begin
            if (mask[k]) begin
                idx = KeyIdxW'(k);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/kar_front.sv */
// front part: takes ticks, tracks levels and hold counters, builds event plans
module kar_front
    import kar_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KeyCount-1:0] i_key_levels,
    input  logic [DelayW-1:0]   i_repeat_delay,
    input  logic [PeriodW-1:0]  i_repeat_period,
    input  logic                i_queue_full,
    output logic                o_push,
    output t_plan               o_plan
);

    logic [KeyCount-1:0] r_prev_levels, n_prev_levels;
    logic [CountW-1:0]   r_hold [KeyCount];
    logic [CountW-1:0]   n_hold [KeyCount];
    logic                accept;
    logic [DelayW:0]     limit;
    logic [CountW-1:0]   inc [KeyCount];
    t_plan               plan;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign limit   = {1'b0, i_repeat_delay} + {{(DelayW - PeriodW + 1){1'b0}}, i_repeat_period};

    always_comb begin
        plan.change = i_key_levels ^ r_prev_levels;
        plan.levels = i_key_levels;
        n_prev_levels = accept ? i_key_levels : r_prev_levels;
        for (int k = 0; k < KeyCount; k++) begin
            inc[k] = (r_hold[k] == CountMax) ? CountMax : r_hold[k] + 1'b1;
            plan.repeat_keys[k] = 1'b0;
            n_hold[k] = r_hold[k];
            if (accept) begin
                if (i_key_levels[k]) begin
                    if (plan.change[k]) begin
                        n_hold[k] = '0;
                    end
                end else if ({1'b0, inc[k]} > limit) begin
                    plan.repeat_keys[k] = 1'b1;
                    n_hold[k] = i_repeat_delay;
                end else begin
                    n_hold[k] = inc[k];
                end
            end
        end
    end

    // ticks without events never enter the queue
    assign o_push = accept && ((|plan.change) || (|plan.repeat_keys));
    assign o_plan = plan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_levels <= '0;
            for (int k = 0; k < KeyCount; k++) begin
                r_hold[k] <= '0;
            end
        end else begin
            r_prev_levels <= n_prev_levels;
            for (int k = 0; k < KeyCount; k++) begin
                r_hold[k] <= n_hold[k];
            end
        end
    end

endmodule

/* rtl/kar_queue.sv */
// two-entry plan queue between front and back
module kar_queue
    import kar_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_plan i_push_plan,
    output logic  o_full,
    input  logic  i_pop,
    output t_plan o_pop_plan,
    output logic  o_empty
);

    t_plan       r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_pop_plan = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/kar_back.sv */
// back part: walks one plan and sends its events one per transfer
module kar_back
    import kar_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_queue_empty,
    input  t_plan              i_plan,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [KeyIdxW-1:0] o_key_index,
    output logic               o_is_release,
    output logic               o_last_of_tick
);

    logic                r_busy, n_busy;
    logic [KeyCount-1:0] r_edge, n_edge;
    logic [KeyCount-1:0] r_rpt, n_rpt;
    logic [KeyCount-1:0] r_lev, n_lev;
    logic                r_phase, n_phase;
    logic                r_out_valid, n_out_valid;
    logic [KeyIdxW-1:0]  r_key;
    logic                r_rel, r_last;

    logic                edge_any;
    logic [KeyIdxW-1:0]  idx;
    logic [KeyCount-1:0] bit_sel;
    logic                ev_rel, ev_last;
    logic                out_load, fire, done;

    always_comb begin
        edge_any = |r_edge;
        idx      = lowest_set(edge_any ? r_edge : r_rpt);
        bit_sel  = '0;
        bit_sel[idx] = 1'b1;
        ev_rel   = edge_any ? r_lev[idx] : r_phase;
        if (edge_any) begin
            ev_last = ((r_edge & ~bit_sel) == '0) && (r_rpt == '0);
        end else begin
            ev_last = r_phase && ((r_rpt & ~bit_sel) == '0);
        end

        out_load = !r_out_valid || !i_stall;
        fire     = r_busy && out_load;
        done     = fire && ev_last;
        o_pop    = !i_queue_empty && (!r_busy || done);

        n_edge  = r_edge;
        n_rpt   = r_rpt;
        n_lev   = r_lev;
        n_phase = r_phase;
        if (o_pop) begin
            n_edge  = i_plan.change;
            n_rpt   = i_plan.repeat_keys;
            n_lev   = i_plan.levels;
            n_phase = 1'b0;
        end else if (fire) begin
            if (edge_any) begin
                n_edge = r_edge & ~bit_sel;
            end else begin
                // repeat pair: press first, then release
                n_phase = ~r_phase;
                if (r_phase) begin
                    n_rpt = r_rpt & ~bit_sel;
                end
            end
        end

        n_busy      = o_pop ? 1'b1 : (done ? 1'b0 : r_busy);
        n_out_valid = fire ? 1'b1 : (!i_stall ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        r_edge  <= n_edge;
        r_rpt   <= n_rpt;
        r_lev   <= n_lev;
        r_phase <= n_phase;
        if (fire) begin
            r_key  <= idx;
            r_rel  <= ev_rel;
            r_last <= ev_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_key_index    = r_key;
    assign o_is_release   = r_rel;
    assign o_last_of_tick = r_last;

endmodule

/* rtl/key_event_autorepeat_core.sv */
// top level of the key event generator with auto-repeat
//
// channel   direction  handshake                  payload
// -------   ---------  -------------------------  ---------------------------------
// in        input      i_in_valid / o_in_stall    i_key_levels
// out       output     o_out_valid / i_out_stall  o_key_index, o_is_release,
//                                                 o_last_of_tick
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// a tick is classified in the cycle of its transfer; its first event passes the
// plan queue, the back part's plan registers and its output register, and the rest
// follow one per cycle while the output is not stalled; a tick yields up to 12 events
// the back part pops the next plan in the cycle of the last event, so plans
// run back to back; ticks with no event only pass through the front
// the two-entry plan queue lets the front take ticks while the back drains
// reset is synchronous and active low; it restores the register defaults and
// clears the previous levels and all hold counters
// o_in_stall rises only when the plan queue is full
module key_event_autorepeat_core
    import kar_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input tick channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KeyCount-1:0] i_key_levels,
    // event channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KeyIdxW-1:0]  o_key_index,
    output logic                o_is_release,
    output logic                o_last_of_tick,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    // configuration registers
    logic [DelayW-1:0]  r_repeat_delay, n_repeat_delay;
    logic [PeriodW-1:0] r_repeat_period, n_repeat_period;

    // front to queue and queue to back
    logic  push, pop, queue_full, queue_empty;
    t_plan push_plan, pop_plan;

    // writes to unknown indexes are dropped
    always_comb begin
        n_repeat_delay  = r_repeat_delay;
        n_repeat_period = r_repeat_period;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgRepeatDelay:  n_repeat_delay = i_cfg_data[DelayW-1:0];
                CfgRepeatPeriod: n_repeat_period = i_cfg_data[PeriodW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay  <= DelayReset;
            r_repeat_period <= PeriodReset;
        end else begin
            r_repeat_delay  <= n_repeat_delay;
            r_repeat_period <= n_repeat_period;
        end
    end

    // edge detect and hold counters; one plan per tick with events
    kar_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_key_levels    (i_key_levels),
        .i_repeat_delay  (r_repeat_delay),
        .i_repeat_period (r_repeat_period),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_plan          (push_plan)
    );

    kar_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_plan (push_plan),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_pop_plan  (pop_plan),
        .o_empty     (queue_empty)
    );

    // serializes edge events first, then repeat press/release pairs
    kar_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_empty  (queue_empty),
        .i_plan         (pop_plan),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_key_index    (o_key_index),
        .o_is_release   (o_is_release),
        .o_last_of_tick (o_last_of_tick)
    );

endmodule
